// ===== hdl/euler_characteristic_2d_defines.svh =====
// ----------------------------------------------------------------------------
// Euler characteristic block: assertion macros
// Clocked assertion helpers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EULER_CHARACTERISTIC_2D_DEFINES_SVH
`define EULER_CHARACTERISTIC_2D_DEFINES_SVH

`ifndef SYNTHESIS
// property checked outside reset
`define EC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("euler block assertion failed");
// property checked during reset too
`define EC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("euler block reset assertion failed");
`else
`define EC_ASSERT(lbl, prop)
`define EC_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== hdl/ec_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler characteristic package
// Shared constants, register codes, item flags and the window delta function.
// ----------------------------------------------------------------------------
package ec_pkg;

  localparam int DEFAULT_MAX_WIDTH  = 1024;
  localparam int DEFAULT_MAX_HEIGHT = 1024;

  localparam int PIX_W  = 16;
  localparam int SIZE_W = 11;
  localparam int SUM_W  = 21;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;
  localparam int DELTA_W = 4;

  localparam logic [SIZE_W-1:0] ROW_LENGTH_RESET = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] ROW_TOTAL_RESET  = SIZE_W'(1024);

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_ROW_LENGTH = 2'd0,
    CFG_ROW_TOTAL  = 2'd1,
    CFG_LEVEL      = 2'd2
  } cfg_index_t;

  // classified pixel, as the front hands it to the back
  typedef struct packed {
    logic fg;         // pixel is foreground
    logic left;       // masked left neighbor
    logic top_row;    // first row of the frame
    logic first_col;  // first column of the row
    logic last_col;   // last column of the row
    logic last_row;   // last row of the frame
  } item_flags_t;

  localparam int FLAGS_W = $bits(item_flags_t);

  // change of the running sum for one window
  function automatic logic signed [DELTA_W-1:0] window_delta(
    input item_flags_t f, input logic up, input logic up_left);
    logic [2:0] add;
    logic [2:0] sub;
    add = 3'({2'b00, f.fg | f.left | up | up_left}) + 3'({2'b00, f.fg});
    sub = 3'({2'b00, f.fg | up}) + 3'({2'b00, f.fg | f.left});
    if (f.last_col) begin
      add = add + 3'({2'b00, f.fg | up});
      sub = sub + 3'({2'b00, f.fg});
    end
    if (f.last_row) begin
      add = add + 3'({2'b00, f.fg | f.left});
      sub = sub + 3'({2'b00, f.fg});
    end
    if (f.last_row && f.last_col) begin
      add = add + 3'({2'b00, f.fg});
    end
    return $signed({1'b0, add}) - $signed({1'b0, sub});
  endfunction

endpackage

// ===== hdl/ec_fifo.sv =====
// ----------------------------------------------------------------------------
// Euler characteristic small queue
// Register queue with full/empty flags; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module ec_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/ec_front.sv =====
// ----------------------------------------------------------------------------
// Euler characteristic front end
// Holds configuration, thresholds pixels and tracks the raster position.
// ----------------------------------------------------------------------------
module ec_front #(
  parameter int MAX_WIDTH  = ec_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ec_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [ec_pkg::IDX_W-1:0]             cfg_index,
  input  logic [ec_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                 accept,
  input  logic signed [ec_pkg::PIX_W-1:0]      gray_value,
  output ec_pkg::item_flags_t                  item_flags,
  output logic [$clog2(MAX_WIDTH)-1:0]         item_col
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int CCMP_W = (COL_W + 1 > ec_pkg::SIZE_W) ? COL_W + 1 : ec_pkg::SIZE_W;
  localparam int RCMP_W = (ROW_W + 1 > ec_pkg::SIZE_W) ? ROW_W + 1 : ec_pkg::SIZE_W;

  logic [ec_pkg::SIZE_W-1:0]       row_length;
  logic [ec_pkg::SIZE_W-1:0]       row_total;
  logic signed [ec_pkg::PIX_W-1:0] level;
  logic [COL_W-1:0]                column_index;
  logic [ROW_W-1:0]                row_index;
  logic                            left_bit;

  logic [CCMP_W-1:0] col_plus;
  logic [RCMP_W-1:0] row_plus;
  logic              last_col;
  logic              last_row;
  logic              fg;

  // position flags against the clamped frame size
  assign col_plus = CCMP_W'(column_index) + 1'b1;
  assign row_plus = RCMP_W'(row_index) + 1'b1;
  assign last_col = (col_plus >= CCMP_W'(row_length)) || (col_plus >= CCMP_W'(MAX_WIDTH));
  assign last_row = (row_plus >= RCMP_W'(row_total)) || (row_plus >= RCMP_W'(MAX_HEIGHT));
  assign fg       = (gray_value <= level);

  // classified item
  always_comb begin
    item_flags.fg        = fg;
    item_flags.top_row   = (row_index == '0);
    item_flags.first_col = (column_index == '0);
    item_flags.left      = (column_index != '0) && left_bit;
    item_flags.last_col  = last_col;
    item_flags.last_row  = last_row;
    item_col             = column_index;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ec_pkg::ROW_LENGTH_RESET;
      row_total  <= ec_pkg::ROW_TOTAL_RESET;
      level      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ec_pkg::CFG_ROW_LENGTH: row_length <= cfg_data[ec_pkg::SIZE_W-1:0];
        ec_pkg::CFG_ROW_TOTAL:  row_total  <= cfg_data[ec_pkg::SIZE_W-1:0];
        ec_pkg::CFG_LEVEL:      level      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // raster position and left neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      left_bit     <= 1'b0;
    end else if (accept) begin
      if (!last_col) begin
        column_index <= column_index + 1'b1;
        left_bit     <= fg;
      end else begin
        column_index <= '0;
        left_bit     <= 1'b0;
        row_index    <= last_row ? '0 : row_index + 1'b1;
      end
    end
  end

endmodule

// ===== hdl/ec_back.sv =====
// ----------------------------------------------------------------------------
// Euler characteristic back end
// Reads the upper row store, accumulates window deltas, issues frame results.
// ----------------------------------------------------------------------------
module ec_back #(
  parameter int MAX_WIDTH = ec_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  ec_pkg::item_flags_t           q_flags,
  input  logic [$clog2(MAX_WIDTH)-1:0]  q_col,
  output logic                          q_pop,
  input  logic                          out_full,
  output logic                          out_push,
  output logic [ec_pkg::SUM_W-1:0]      out_data,
  output logic                          frame_retire
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic                        upper_row_bits [MAX_WIDTH];
  logic                        s1_valid;
  ec_pkg::item_flags_t         s1_flags;
  logic [COL_W-1:0]            s1_col;
  logic                        rd_bit;
  logic                        upper_left_bit;
  logic [ec_pkg::SUM_W-1:0]    running_sum;

  logic                              frame_end;
  logic                              retire;
  logic                              up;
  logic                              up_left;
  logic signed [ec_pkg::DELTA_W-1:0] delta;
  logic [ec_pkg::SUM_W-1:0]          sum_next;

  // stage control
  assign frame_end    = s1_flags.last_col && s1_flags.last_row;
  assign retire       = s1_valid && !(frame_end && out_full);
  assign q_pop        = !q_empty && (!s1_valid || retire);
  assign frame_retire = retire && frame_end;

  // window and sum
  assign up       = !s1_flags.top_row && rd_bit;
  assign up_left  = !s1_flags.top_row && !s1_flags.first_col && upper_left_bit;
  assign delta    = ec_pkg::window_delta(s1_flags, up, up_left);
  assign sum_next = running_sum + {{(ec_pkg::SUM_W - ec_pkg::DELTA_W){delta[ec_pkg::DELTA_W-1]}},
                                   delta};

  assign out_push = frame_retire;
  assign out_data = sum_next;

  // row store: registered read with bypass of a same-column write
  always_ff @(posedge clk) begin
    if (retire) begin
      upper_row_bits[s1_col] <= s1_flags.fg;
    end
    if (q_pop) begin
      rd_bit   <= (retire && (s1_col == q_col)) ? s1_flags.fg : upper_row_bits[q_col];
      s1_flags <= q_flags;
      s1_col   <= q_col;
    end
  end

  // stage valid, diagonal neighbor and running sum
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      upper_left_bit <= 1'b0;
      running_sum    <= '0;
    end else begin
      if (q_pop) begin
        s1_valid <= 1'b1;
      end else if (retire) begin
        s1_valid <= 1'b0;
      end
      if (retire) begin
        upper_left_bit <= s1_flags.last_col ? 1'b0 : up;
        running_sum    <= frame_end ? '0 : sum_next;
      end
    end
  end

endmodule

// ===== hdl/euler_characteristic_2d.sv =====
// ----------------------------------------------------------------------------
// Euler characteristic of a thresholded 2D image
// Streams grey pixels and reports one Euler number per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive gray_value and push; the pixel is taken at an edge with
//   push high and full low. Pixels come in raster order, row by row.
//   Result queue: while empty is low, euler_number holds the oldest result;
//   pop at an edge with empty low takes it. One result per frame, after the
//   last pixel of the frame.
//   Configuration: cfg_write with cfg_index/cfg_data sets row_length,
//   row_total or level; write only while the block is idle.
// Timing:
//   One pixel per cycle sustained while the result queue has room. A pixel
//   passes the front, a two-entry queue and one back stage; a frame's result
//   is pushed from the back stage into the result queue. The back stage is
//   bound by the single read port of the row store, one pixel per cycle.
// Reset: clears position, sum, queues and loads default configuration.
// Stall: results wait in a two-entry queue; once it fills, the back stage
//   holds the next frame-end pixel and the input queue fills, raising full.
// ----------------------------------------------------------------------------
`include "euler_characteristic_2d_defines.svh"

module euler_characteristic_2d #(
  parameter int MAX_WIDTH  = ec_pkg::DEFAULT_MAX_WIDTH,
  parameter int MAX_HEIGHT = ec_pkg::DEFAULT_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ec_pkg::IDX_W-1:0]         cfg_index,
  input  logic [ec_pkg::CFG_W-1:0]         cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic signed [ec_pkg::PIX_W-1:0]  gray_value,
  input  logic                             pop,
  output logic                             empty,
  output logic signed [ec_pkg::SUM_W-1:0]  euler_number
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ITEM_W = ec_pkg::FLAGS_W + COL_W;

  logic                     accept;
  ec_pkg::item_flags_t      f_flags;
  logic [COL_W-1:0]         f_col;
  logic [ITEM_W-1:0]        q_data;
  logic                     q_empty;
  logic                     q_pop;
  ec_pkg::item_flags_t      q_flags;
  logic [COL_W-1:0]         q_col;
  logic                     out_full;
  logic                     out_push;
  logic [ec_pkg::SUM_W-1:0] out_data;
  logic [ec_pkg::SUM_W-1:0] result;
  logic                     frame_retire;

  assign accept       = push && !full;
  assign q_flags      = q_data[ITEM_W-1:COL_W];
  assign q_col        = q_data[COL_W-1:0];
  assign euler_number = $signed(result);

  // front: configuration and classification
  ec_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .gray_value (gray_value),
    .item_flags (f_flags),
    .item_col   (f_col)
  );

  // queue between front and back
  ec_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (2)
  ) u_item_q (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data ({f_flags, f_col}),
    .full      (full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back: row store and accumulation
  ec_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_flags      (q_flags),
    .q_col        (q_col),
    .q_pop        (q_pop),
    .out_full     (out_full),
    .out_push     (out_push),
    .out_data     (out_data),
    .frame_retire (frame_retire)
  );

  // result queue
  ec_fifo #(
    .WIDTH (ec_pkg::SUM_W),
    .DEPTH (2)
  ) u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (out_data),
    .full      (out_full),
    .pop       (pop),
    .pop_data  (result),
    .empty     (empty)
  );

  // checks
  `EC_ASSERT_RST(a_reset_clears, rst |=> (empty && !full))
  `EC_ASSERT(a_result_has_room, frame_retire |-> !out_full)
  `EC_ASSERT(a_result_after_frame_end, (out_push && !out_full) |=> !empty)

endmodule
